@@ hdl/stbs_pkg.sv @@
// Shared types and constants for the sorted-table binary search block.
`default_nettype none

package stbs_pkg;

   // Table geometry.
   localparam int TABLE_DEPTH = 1024;
   localparam int ENTRY_WIDTH = 32;
   localparam int ADDR_WIDTH  = $clog2(TABLE_DEPTH);
   localparam int COUNT_WIDTH = 11;
   localparam int INDEX_WIDTH = 10;
   localparam int SUM_WIDTH   = COUNT_WIDTH + 1;

   // Operation codes of an input word.
   localparam logic OP_WRITE  = 1'b0;
   localparam logic OP_SEARCH = 1'b1;

   // Input word: a table write or a search key.
   typedef struct packed {
      logic                           op;
      logic [INDEX_WIDTH-1:0]         index;
      logic signed [ENTRY_WIDTH-1:0]  value;
   } req_word_type;

   // Result word of one search.
   typedef struct packed {
      logic                   found;
      logic [INDEX_WIDTH-1:0] match_index;
   } rsp_word_type;

   // Access request from the sequencer to the table memory.
   typedef struct packed {
      logic                           wr_en;
      logic [ADDR_WIDTH-1:0]          wr_addr;
      logic signed [ENTRY_WIDTH-1:0]  wr_data;
      logic                           rd_en;
      logic [ADDR_WIDTH-1:0]          rd_addr;
   } ram_req_type;

endpackage

`default_nettype wire

@@ hdl/stbs_table_ram.sv @@
// Table memory: one write port and one read port with registered read data.
`default_nettype none

module stbs_table_ram (
   input  wire                                   clock,
   input  stbs_pkg::ram_req_type                 ram_req,
   output logic signed [stbs_pkg::ENTRY_WIDTH-1:0] rd_data
);
   import stbs_pkg::*;

   logic signed [ENTRY_WIDTH-1:0] mem [TABLE_DEPTH];
   logic signed [ENTRY_WIDTH-1:0] rd_data_ff;

   // Write port.
   always_ff @(posedge clock) begin
      if (ram_req.wr_en) begin
         mem[ram_req.wr_addr] <= ram_req.wr_data;
      end
   end

   // Read port; the read data is registered.
   always_ff @(posedge clock) begin
      if (ram_req.rd_en) begin
         rd_data_ff <= mem[ram_req.rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

@@ hdl/stbs_search_ctrl.sv @@
// Search sequencer: takes input words, drives the table memory and holds the result register.
`default_nettype none

module stbs_search_ctrl (
   input  wire                                     clock,
   input  wire                                     reset,
   input  wire                                     req_valid,
   output logic                                    req_stall,
   input  stbs_pkg::req_word_type                  req_word,
   output logic                                    rsp_valid,
   input  wire                                     rsp_stall,
   output stbs_pkg::rsp_word_type                  rsp_word,
   input  wire [stbs_pkg::COUNT_WIDTH-1:0]         entry_count,
   output stbs_pkg::ram_req_type                   ram_req,
   input  wire signed [stbs_pkg::ENTRY_WIDTH-1:0]  rd_data
);
   import stbs_pkg::*;

   localparam logic [1:0] ST_IDLE   = 2'd0;
   localparam logic [1:0] ST_PROBE  = 2'd1;
   localparam logic [1:0] ST_CHECK  = 2'd2;
   localparam logic [1:0] ST_FINISH = 2'd3;

   logic [1:0]                    state_ff, state_in;
   logic [COUNT_WIDTH-1:0]        lo_ff, lo_in;
   logic [COUNT_WIDTH-1:0]        hi1_ff, hi1_in;
   logic [ADDR_WIDTH-1:0]         mid_ff, mid_in;
   logic signed [ENTRY_WIDTH-1:0] key_ff, key_in;
   logic                          hit_ff, hit_in;
   logic                          rsp_valid_ff, rsp_valid_in;
   rsp_word_type                  rsp_word_ff, rsp_word_in;

   logic                          req_take;
   logic                          rsp_free;
   logic [SUM_WIDTH-1:0]          mid_sum;
   logic [ADDR_WIDTH-1:0]         mid_probe;
   logic [COUNT_WIDTH-1:0]        count_clamped;

   assign req_stall = (state_ff != ST_IDLE);
   assign req_take  = req_valid && !req_stall;
   assign rsp_free  = !rsp_valid_ff || !rsp_stall;

   // The upper bound is kept as one past the last candidate entry.
   assign count_clamped = (entry_count > COUNT_WIDTH'(TABLE_DEPTH)) ?
                          COUNT_WIDTH'(TABLE_DEPTH) : entry_count;
   assign mid_sum   = {1'b0, lo_ff} + {1'b0, hi1_ff} - SUM_WIDTH'(1);
   assign mid_probe = mid_sum[ADDR_WIDTH:1];

   // Memory requests: writes straight from the input word, reads for each probe.
   always_comb begin
      ram_req         = '0;
      ram_req.wr_en   = req_take && (req_word.op == OP_WRITE);
      ram_req.wr_addr = ADDR_WIDTH'(req_word.index);
      ram_req.wr_data = req_word.value;
      ram_req.rd_en   = (state_ff == ST_PROBE) && (lo_ff < hi1_ff);
      ram_req.rd_addr = mid_probe;
   end

   // Next-state logic of the search.
   always_comb begin
      state_in     = state_ff;
      lo_in        = lo_ff;
      hi1_in       = hi1_ff;
      mid_in       = mid_ff;
      key_in       = key_ff;
      hit_in       = hit_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_word_in  = rsp_word_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_take && (req_word.op == OP_SEARCH)) begin
               lo_in    = '0;
               hi1_in   = count_clamped;
               key_in   = req_word.value;
               hit_in   = 1'b0;
               mid_in   = '0;
               state_in = ST_PROBE;
            end
         end
         ST_PROBE: begin
            if (lo_ff < hi1_ff) begin
               mid_in   = mid_probe;
               state_in = ST_CHECK;
            end else begin
               // Range is empty: the key is absent.
               hit_in   = 1'b0;
               mid_in   = '0;
               state_in = ST_FINISH;
            end
         end
         ST_CHECK: begin
            if (rd_data == key_ff) begin
               hit_in   = 1'b1;
               state_in = ST_FINISH;
            end else if (key_ff > rd_data) begin
               lo_in    = {1'b0, mid_ff} + COUNT_WIDTH'(1);
               state_in = ST_PROBE;
            end else begin
               hi1_in   = {1'b0, mid_ff};
               state_in = ST_PROBE;
            end
         end
         ST_FINISH: begin
            // Load the result register once it is free or being emptied.
            if (rsp_free) begin
               rsp_valid_in            = 1'b1;
               rsp_word_in.found       = hit_ff;
               rsp_word_in.match_index = hit_ff ? INDEX_WIDTH'(mid_ff) : '0;
               state_in                = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         lo_ff        <= '0;
         hi1_ff       <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         lo_ff        <= lo_in;
         hi1_ff       <= hi1_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      mid_ff      <= mid_in;
      key_ff      <= key_in;
      hit_ff      <= hit_in;
      rsp_word_ff <= rsp_word_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

   // A table write only happens while no search is in flight.
   assert property (@(posedge clock) disable iff (reset)
      ram_req.wr_en |-> (state_ff == ST_IDLE) && !ram_req.rd_en)
      else $error("table write overlaps a search");

   // Each probe lies inside the current search range.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CHECK) |-> (lo_ff <= {1'b0, mid_ff}) && ({1'b0, mid_ff} < hi1_ff))
      else $error("probe outside search range");

   // A compare always follows a read issued in the cycle before.
   assert property (@(posedge clock) disable iff (reset)
      ram_req.rd_en |=> (state_ff == ST_CHECK))
      else $error("read data not checked in the following cycle");

   // The upper bound never exceeds the table depth.
   assert property (@(posedge clock) disable iff (reset)
      hi1_ff <= COUNT_WIDTH'(TABLE_DEPTH))
      else $error("search bound beyond table depth");

   // A miss always reports index zero.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_word_ff.found || (rsp_word_ff.match_index == '0)))
      else $error("miss with nonzero index");

endmodule

`default_nettype wire

@@ hdl/sorted_table_binary_search.sv @@
// Top level of the sorted-table binary search block.
//
// Usage: input words arrive on req_valid/req_stall/req_word. A word with op
// set to write stores value at table entry index and gives no result. A
// word with op set to search runs a binary search over entries 0 to
// entry_count-1 and gives one result word on rsp_valid/rsp_stall/rsp_word
// (found and match_index, index zero on a miss). The user must write
// entry_count through csr_wr_en/csr_wr_data only while idle; the block
// itself does not enforce this. Values above the table depth are treated
// as the depth. A search runs a probe state (memory read) and a check
// state (compare) for each probe, at most 11 probes for 1024 entries,
// then a finish state that loads the result; an empty range is closed in
// the probe state. The single table read port sets this order, and one
// search is worked on at a time, with req_stall high while it runs.
// The result register holds a finished word while the receiver stalls; a
// new word is still accepted, and a later search waits in its last step
// until the register is free. Reset clears entry_count and all control
// state; table contents are undefined until written.
`default_nettype none

module sorted_table_binary_search (
   input  wire                              clock,
   input  wire                              reset,
   input  wire                              req_valid,
   output logic                             req_stall,
   input  stbs_pkg::req_word_type           req_word,
   output logic                             rsp_valid,
   input  wire                              rsp_stall,
   output stbs_pkg::rsp_word_type           rsp_word,
   input  wire                              csr_wr_en,
   input  wire [stbs_pkg::COUNT_WIDTH-1:0]  csr_wr_data
);
   import stbs_pkg::*;

   logic [COUNT_WIDTH-1:0]        entry_count_ff, entry_count_in;
   ram_req_type                   ram_req;
   logic signed [ENTRY_WIDTH-1:0] rd_data;

   // Entry count register.
   assign entry_count_in = csr_wr_en ? csr_wr_data : entry_count_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         entry_count_ff <= '0;
      end else begin
         entry_count_ff <= entry_count_in;
      end
   end

   // Search sequencer.
   stbs_search_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_word    (req_word),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_word    (rsp_word),
      .entry_count (entry_count_ff),
      .ram_req     (ram_req),
      .rd_data     (rd_data)
   );

   // Table memory.
   stbs_table_ram u_ram (
      .clock   (clock),
      .ram_req (ram_req),
      .rd_data (rd_data)
   );

endmodule

`default_nettype wire
